// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point-line incidence check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point-line incidence check failed");

`endif

// ===== hdl/upli_pkg.sv =====
// Shared types, constants and the operand step table of the incidence block.
// Depends on nothing; imported by every module of the block but upli_ram.
`timescale 1ns / 1ps

package upli_pkg;

   // Operand store layout.
   localparam int NUM_SLOTS = 24;
   localparam int SLOT_W    = 5;
   localparam int VALUE_W   = 16;
   localparam int SLOT_X    = 0;
   localparam int SLOT_SX   = 3;
   localparam int SLOT_L    = 12;
   localparam int SLOT_SL   = 15;

   // Configuration and result widths.
   localparam int THR_W = 16;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd983;
   localparam int DIST_W  = 33;
   localparam int VAR_W   = 51;
   localparam int SPLIT_W = 32;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Sequencer: six operand loads, three dot terms, nine terms per quadratic form.
   localparam int NUM_STEPS = 27;
   localparam int STEP_W    = 5;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

   typedef enum logic [2:0] {
      OPND_X0,
      OPND_X1,
      OPND_X2,
      OPND_L0,
      OPND_L1,
      OPND_L2,
      OPND_ONE
   } opnd_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_DOT,
      ACC_QL,
      ACC_QX
   } acc_type;

   // One sequencer step: read address, two factor selects and the target sum.
   // A step with ACC_NONE loads the read word into the register named by b_sel.
   typedef struct packed {
      logic [SLOT_W-1:0] addr;
      opnd_type          b_sel;
      opnd_type          c_sel;
      acc_type           acc;
   } step_type;

   // One queued item as classified by the front part.
   typedef struct packed {
      logic               we;
      logic               last;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
   } q_item_type;

   function automatic step_type mk_step(input int addr, input opnd_type b,
                                        input opnd_type c, input acc_type acc);
      step_type s;
      s.addr  = SLOT_W'(addr);
      s.b_sel = b;
      s.c_sel = c;
      s.acc   = acc;
      return s;
   endfunction

   // Step table. A quadratic-form term v[i] * S[i][j] * v[j] reads S[i][j]
   // and multiplies by v[j], then by v[i].
   function automatic step_type step_info(input logic [STEP_W-1:0] k);
      step_type s;
      case (k)
         5'd0:  s = mk_step(SLOT_X + 0, OPND_X0, OPND_ONE, ACC_NONE);
         5'd1:  s = mk_step(SLOT_X + 1, OPND_X1, OPND_ONE, ACC_NONE);
         5'd2:  s = mk_step(SLOT_X + 2, OPND_X2, OPND_ONE, ACC_NONE);
         5'd3:  s = mk_step(SLOT_L + 0, OPND_L0, OPND_ONE, ACC_NONE);
         5'd4:  s = mk_step(SLOT_L + 1, OPND_L1, OPND_ONE, ACC_NONE);
         5'd5:  s = mk_step(SLOT_L + 2, OPND_L2, OPND_ONE, ACC_NONE);
         5'd6:  s = mk_step(SLOT_X + 0, OPND_L0, OPND_ONE, ACC_DOT);
         5'd7:  s = mk_step(SLOT_X + 1, OPND_L1, OPND_ONE, ACC_DOT);
         5'd8:  s = mk_step(SLOT_X + 2, OPND_L2, OPND_ONE, ACC_DOT);
         5'd9:  s = mk_step(SLOT_SX + 0, OPND_L0, OPND_L0, ACC_QL);
         5'd10: s = mk_step(SLOT_SX + 1, OPND_L1, OPND_L0, ACC_QL);
         5'd11: s = mk_step(SLOT_SX + 2, OPND_L2, OPND_L0, ACC_QL);
         5'd12: s = mk_step(SLOT_SX + 3, OPND_L0, OPND_L1, ACC_QL);
         5'd13: s = mk_step(SLOT_SX + 4, OPND_L1, OPND_L1, ACC_QL);
         5'd14: s = mk_step(SLOT_SX + 5, OPND_L2, OPND_L1, ACC_QL);
         5'd15: s = mk_step(SLOT_SX + 6, OPND_L0, OPND_L2, ACC_QL);
         5'd16: s = mk_step(SLOT_SX + 7, OPND_L1, OPND_L2, ACC_QL);
         5'd17: s = mk_step(SLOT_SX + 8, OPND_L2, OPND_L2, ACC_QL);
         5'd18: s = mk_step(SLOT_SL + 0, OPND_X0, OPND_X0, ACC_QX);
         5'd19: s = mk_step(SLOT_SL + 1, OPND_X1, OPND_X0, ACC_QX);
         5'd20: s = mk_step(SLOT_SL + 2, OPND_X2, OPND_X0, ACC_QX);
         5'd21: s = mk_step(SLOT_SL + 3, OPND_X0, OPND_X1, ACC_QX);
         5'd22: s = mk_step(SLOT_SL + 4, OPND_X1, OPND_X1, ACC_QX);
         5'd23: s = mk_step(SLOT_SL + 5, OPND_X2, OPND_X1, ACC_QX);
         5'd24: s = mk_step(SLOT_SL + 6, OPND_X0, OPND_X2, ACC_QX);
         5'd25: s = mk_step(SLOT_SL + 7, OPND_X1, OPND_X2, ACC_QX);
         5'd26: s = mk_step(SLOT_SL + 8, OPND_X2, OPND_X2, ACC_QX);
         default: s = mk_step(SLOT_X, OPND_X0, OPND_ONE, ACC_NONE);
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/upli_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module upli_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/upli_front.sv =====
// Front part: accepts input items, classifies them and queues the useful ones.
// Depends on upli_pkg.
`timescale 1ns / 1ps

module upli_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [upli_pkg::SLOT_W-1:0]  req_slot,
   input  logic [upli_pkg::VALUE_W-1:0] req_value,
   input  logic                       req_last,
   output logic                       q_valid,
   output upli_pkg::q_item_type       q_item,
   input  logic                       q_pop
);

   import upli_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_item_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   q_item_type       item;
   logic             accept;
   logic             push;
   logic             full;

   // Classify: an in-range slot is a store, a set last flag starts a computation.
   // Items that do neither are dropped here.
   always_comb begin
      item.we    = (req_slot < SLOT_W'(NUM_SLOTS));
      item.last  = req_last;
      item.slot  = req_slot;
      item.value = req_value;
   end

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (item.we || item.last);
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== hdl/upli_back.sv =====
// Back part: stores operands, runs the multiply-accumulate sequence and the
// incidence test, and holds the result register. Depends on upli_pkg, upli_ram.
`timescale 1ns / 1ps

module upli_back #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  upli_pkg::q_item_type              q_item,
   output logic                              q_pop,
   input  logic [upli_pkg::THR_W-1:0]        threshold,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [upli_pkg::DIST_W-1:0] rsp_alg_distance,
   output logic signed [upli_pkg::VAR_W-1:0]  rsp_alg_variance,
   output logic signed [upli_pkg::VAR_W-1:0]  rsp_test_variance,
   output logic                              rsp_incident,
   output logic                              rsp_variance_invalid
);

   import upli_pkg::*;

   localparam int ADDR_W = $clog2(NUM_SLOTS);
   localparam int P1_W   = 2 * DATA_WIDTH;
   localparam int P2_W   = 3 * DATA_WIDTH;
   localparam int DOT_W  = 2 * DATA_WIDTH + 1;
   localparam int QF_W   = 3 * DATA_WIDTH + 2;
   localparam int MAG_W  = 2 * DATA_WIDTH;
   localparam int D2_W   = 4 * DATA_WIDTH;
   localparam int PLO_W  = THR_W + SPLIT_W;
   localparam int PHI_W  = THR_W + VAR_W - SPLIT_W;
   localparam int PROD_W = THR_W + VAR_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RUN  = 5'b00010,
      ST_FIN1 = 5'b00100,
      ST_FIN2 = 5'b01000,
      ST_FIN3 = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [STEP_W-1:0]         s1_step_ff, s2_step_ff, s3_step_ff;
   step_type                  info0, info1, info2, info3;
   logic                      issue, start, run_done, out_free, rsp_load;
   logic                      ram_we;
   logic [DATA_WIDTH-1:0]     rd_data;
   logic signed [DATA_WIDTH-1:0] rd_sdata, b_val, c_val;
   logic signed [DATA_WIDTH-1:0] x0_ff, x1_ff, x2_ff, l0_ff, l1_ff, l2_ff;
   logic signed [P1_W-1:0]    p1_ff;
   logic signed [P2_W-1:0]    p2_ff;
   logic signed [DOT_W-1:0]   dot_ff;
   logic signed [QF_W-1:0]    ql_ff, qx_ff;
   logic                      w_pos, w_neg;
   logic signed [DIST_W-1:0]  dot_ext, dist_in, dist_ff;
   logic signed [VAR_W-1:0]   ql_ext, qx_ext, avar_ff, tvar_ff;
   logic [MAG_W-1:0]          mag_ff;
   logic [D2_W-1:0]           d2_ff;
   logic [PLO_W-1:0]          plo_ff;
   logic [PHI_W-1:0]          phi_ff;
   logic [PROD_W-1:0]         prod;
   logic                      invalid_ff;
   logic                      rsp_valid_ff;
   logic signed [DIST_W-1:0]  rsp_dist_ff;
   logic signed [VAR_W-1:0]   rsp_avar_ff, rsp_tvar_ff;
   logic                      rsp_incident_ff, rsp_invalid_ff;

   function automatic logic signed [DATA_WIDTH-1:0] pick(
      input opnd_type sel,
      input logic signed [DATA_WIDTH-1:0] a0, a1, a2, a3, a4, a5);
      logic signed [DATA_WIDTH-1:0] r;
      case (sel)
         OPND_X0: r = a0;
         OPND_X1: r = a1;
         OPND_X2: r = a2;
         OPND_L0: r = a3;
         OPND_L1: r = a4;
         OPND_L2: r = a5;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Operand store.
   upli_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(NUM_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ADDR_W'(q_item.slot)),
      .wr_data(q_item.value[DATA_WIDTH-1:0]),
      .rd_addr(ADDR_W'(info0.addr)),
      .rd_data(rd_data)
   );

   // Queue handling: items are drained one per cycle while idle.
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign ram_we   = q_pop && q_item.we;
   assign start    = q_pop && q_item.last;
   assign rd_sdata = $signed(rd_data);

   // Step lookups for the issue point and each pipeline stage.
   always_comb begin
      info0 = step_info(step_ff);
      info1 = step_info(s1_step_ff);
      info2 = step_info(s2_step_ff);
      info3 = step_info(s3_step_ff);
      b_val = pick(info1.b_sel, x0_ff, x1_ff, x2_ff, l0_ff, l1_ff, l2_ff);
      c_val = pick(info2.c_sel, x0_ff, x1_ff, x2_ff, l0_ff, l1_ff, l2_ff);
   end

   assign issue    = (state_ff == ST_RUN) && (step_ff < STEP_W'(NUM_STEPS));
   assign run_done = s3_valid_ff && (s3_step_ff == LAST_STEP);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_FIN3) && out_free;

   // Sequencer state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               step_in = step_ff + 1'b1;
            end
            if (run_done) begin
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: state_in = ST_FIN3;
         ST_FIN3: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Stage tags follow the read data down the multiply pipeline.
   always_ff @(posedge clock) begin
      s1_step_ff <= step_ff;
      s2_step_ff <= s1_step_ff;
      s3_step_ff <= s2_step_ff;
   end

   // Operand loads and the multiplies of each term: one for a dot term, two for a quadratic-form term.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && info1.acc == ACC_NONE) begin
         case (info1.b_sel)
            OPND_X0: x0_ff <= rd_sdata;
            OPND_X1: x1_ff <= rd_sdata;
            OPND_X2: x2_ff <= rd_sdata;
            OPND_L0: l0_ff <= rd_sdata;
            OPND_L1: l1_ff <= rd_sdata;
            OPND_L2: l2_ff <= rd_sdata;
            default: ;
         endcase
      end
      p1_ff <= P1_W'(rd_sdata) * P1_W'(b_val);
      p2_ff <= (info2.c_sel == OPND_ONE) ? P2_W'(p1_ff) : P2_W'(p1_ff) * P2_W'(c_val);
   end

   // Accumulators for the dot product and the two quadratic forms.
   always_ff @(posedge clock) begin
      if (start) begin
         dot_ff <= '0;
         ql_ff  <= '0;
         qx_ff  <= '0;
      end else if (s3_valid_ff) begin
         case (info3.acc)
            ACC_DOT: dot_ff <= dot_ff + DOT_W'(p2_ff);
            ACC_QL:  ql_ff  <= ql_ff + QF_W'(p2_ff);
            ACC_QX:  qx_ff  <= qx_ff + QF_W'(p2_ff);
            default: ;
         endcase
      end
   end

   // Sign of w selects the signed distance and the line term of the variance.
   always_comb begin
      w_neg   = x2_ff[DATA_WIDTH-1];
      w_pos   = !x2_ff[DATA_WIDTH-1] && (x2_ff != '0);
      dot_ext = DIST_W'(dot_ff);
      ql_ext  = VAR_W'(ql_ff);
      qx_ext  = VAR_W'(qx_ff);
      if (w_neg) begin
         dist_in = -dot_ext;
      end else if (w_pos) begin
         dist_in = dot_ext;
      end else begin
         dist_in = '0;
      end
      prod = PROD_W'({phi_ff, {SPLIT_W{1'b0}}}) + PROD_W'(plo_ff);
   end

   // Finishing steps: sums, then squared distance and scaled variance, then compare.
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN1) begin
         dist_ff <= dist_in;
         avar_ff <= ql_ext + ((w_neg || w_pos) ? qx_ext : '0);
         tvar_ff <= ql_ext + qx_ext;
         mag_ff  <= MAG_W'(dot_ff[DOT_W-1] ? -dot_ff : dot_ff);
      end
      if (state_ff == ST_FIN2) begin
         d2_ff      <= D2_W'(mag_ff) * D2_W'(mag_ff);
         plo_ff     <= PLO_W'(threshold) * PLO_W'(tvar_ff[SPLIT_W-1:0]);
         phi_ff     <= PHI_W'(threshold) * PHI_W'(tvar_ff[VAR_W-1:SPLIT_W]);
         invalid_ff <= tvar_ff[VAR_W-1] || (tvar_ff == '0);
      end
      if (rsp_load) begin
         rsp_dist_ff     <= dist_ff;
         rsp_avar_ff     <= avar_ff;
         rsp_tvar_ff     <= tvar_ff;
         rsp_incident_ff <= !invalid_ff && (PROD_W'(d2_ff) < prod);
         rsp_invalid_ff  <= invalid_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_alg_distance     = rsp_dist_ff;
   assign rsp_alg_variance     = rsp_avar_ff;
   assign rsp_test_variance    = rsp_tvar_ff;
   assign rsp_incident         = rsp_incident_ff;
   assign rsp_variance_invalid = rsp_invalid_ff;

endmodule

// ===== hdl/uncertain_point_line_incidence.sv =====
// Throughput: one operand item per cycle while the queue has room; the queue is drained
// only while the sequencer is idle. A set is computed by one shared multiply pipeline
// reading the operand RAM one word per cycle, while the queue fills and input then stalls.
// Reset (synchronous, active high) empties the queue, idles the sequencer, drops any
// pending result and sets the threshold to 983; operand contents are kept.
`timescale 1ns / 1ps

module uncertain_point_line_incidence #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [upli_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [upli_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [upli_pkg::DIST_W-1:0] rsp_alg_distance,
   output logic signed [upli_pkg::VAR_W-1:0]  rsp_alg_variance,
   output logic signed [upli_pkg::VAR_W-1:0]  rsp_test_variance,
   output logic                               rsp_incident,
   output logic                               rsp_variance_invalid,
   input  logic                               csr_wr_en,
   input  logic [upli_pkg::THR_W-1:0]         csr_wr_data
);

   import upli_pkg::*;

   logic [THR_W-1:0] threshold_ff;
   logic             q_valid;
   q_item_type       q_item;
   logic             q_pop;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   upli_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_slot (req_slot),
      .req_value(req_value),
      .req_last (req_last),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   upli_back #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .threshold           (threshold_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_alg_distance    (rsp_alg_distance),
      .rsp_alg_variance    (rsp_alg_variance),
      .rsp_test_variance   (rsp_test_variance),
      .rsp_incident        (rsp_incident),
      .rsp_variance_invalid(rsp_variance_invalid)
   );

endmodule

// ===== hdl/upli_check.sv =====
// Port-level checker for the incidence block, bound to the top level.
// Depends on upli_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module upli_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [upli_pkg::DIST_W-1:0] rsp_alg_distance,
   input logic signed [upli_pkg::VAR_W-1:0]  rsp_alg_variance,
   input logic signed [upli_pkg::VAR_W-1:0]  rsp_test_variance,
   input logic                               rsp_incident,
   input logic                               rsp_variance_invalid
);

   import upli_pkg::*;

   // A stalled result stays and keeps its distance, test variance and incidence flag.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_alg_distance) && $stable(rsp_test_variance) && $stable(rsp_incident))

   // An invalid variance never reports incidence.
   `ASSERT_IMPLIES(a_no_incident_when_invalid, clock, reset, rsp_valid && rsp_variance_invalid, !rsp_incident)

   // The invalid flag is set exactly when the test variance is negative or zero.
   `ASSERT_IMPLIES(a_invalid_matches_sign, clock, reset, rsp_valid, rsp_variance_invalid == (rsp_test_variance[VAR_W-1] || (rsp_test_variance == '0)))

   // A nonzero distance means w is nonzero, so both variances carry both terms.
   `ASSERT_IMPLIES(a_variances_agree, clock, reset, rsp_valid && (rsp_alg_distance != '0), rsp_alg_variance == rsp_test_variance)

endmodule

bind uncertain_point_line_incidence upli_check u_check (.*);

// ===== bench/upli_checker.sv =====
// Result checker for the point-line incidence block: tracks the operand store and
// threshold, predicts each result and compares it with what the block returns.
// Depends on upli_pkg for widths, slot layout and the threshold reset value.
`timescale 1ns / 1ps

module upli_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [upli_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [upli_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_last,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [upli_pkg::DIST_W-1:0] rsp_alg_distance,
   input  logic signed [upli_pkg::VAR_W-1:0]  rsp_alg_variance,
   input  logic signed [upli_pkg::VAR_W-1:0]  rsp_test_variance,
   input  logic                               rsp_incident,
   input  logic                               rsp_variance_invalid,
   input  logic                               csr_wr_en,
   input  logic [upli_pkg::THR_W-1:0]         csr_wr_data,
   output int unsigned                        n_pending,
   output int unsigned                        n_fail
);

   import upli_pkg::*;

   // One predicted result item.
   typedef struct {
      logic signed [DIST_W-1:0] distance;
      logic signed [VAR_W-1:0]  alg_var;
      logic signed [VAR_W-1:0]  test_var;
      logic                     incident;
      logic                     invalid;
   } verdict_type;

   logic signed [VALUE_W-1:0] operands [NUM_SLOTS] = '{default: '0};
   logic [THR_W-1:0]          threshold;
   verdict_type               expected_verdicts [$];

   // Exact v' S v with the vector at base vb and the row-major matrix at base sb.
   function automatic longint quad_form(input int vb, input int sb);
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            acc += longint'(operands[vb + i]) * longint'(operands[sb + 3 * i + j]) *
                   longint'(operands[vb + j]);
      return acc;
   endfunction

   // Distance, both variances and the incidence decision from the stored operands.
   function automatic verdict_type predict_incidence();
      verdict_type       v;
      longint            dot;
      longint            sgn;
      longint            ql;
      longint            qx;
      longint            avar;
      longint            tvar;
      longint unsigned   mag;
      logic [127:0]      d2;
      logic [127:0]      bound;
      dot = 0;
      for (int i = 0; i < 3; i++)
         dot += longint'(operands[SLOT_X + i]) * longint'(operands[SLOT_L + i]);
      sgn = (operands[SLOT_X + 2] > 0) ? 1 : ((operands[SLOT_X + 2] < 0) ? -1 : 0);
      ql = quad_form(SLOT_L, SLOT_SX);
      qx = quad_form(SLOT_X, SLOT_SL);
      avar = ql + sgn * sgn * qx;
      tvar = ql + qx;
      v.distance = DIST_W'(sgn * dot);
      v.alg_var  = VAR_W'(avar);
      v.test_var = VAR_W'(tvar);
      v.invalid  = (tvar <= 0);
      v.incident = 1'b0;
      if (!v.invalid) begin
         // Compare the squared distance with threshold times variance at full width.
         mag = (dot < 0) ? -dot : dot;
         d2 = 128'(mag) * 128'(mag);
         bound = 128'(threshold) * 128'(tvar);
         v.incident = (d2 < bound);
      end
      return v;
   endfunction

   // Fold in configuration writes, then compare results, then fold in accepted items.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         expected_verdicts.delete();
         threshold = THRESHOLD_RESET;
      end else begin
         if (csr_wr_en)
            threshold = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("mismatch at %0t: result item with none outstanding", $time);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_alg_distance !== want.distance || rsp_alg_variance !== want.alg_var ||
                   rsp_test_variance !== want.test_var || rsp_incident !== want.incident ||
                   rsp_variance_invalid !== want.invalid) begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display({"mismatch at %0t (expected/actual): distance %0d/%0d ",
                               "alg_var %0d/%0d test_var %0d/%0d incident %0b/%0b ",
                               "invalid %0b/%0b"}, $time,
                              want.distance, rsp_alg_distance,
                              want.alg_var, rsp_alg_variance,
                              want.test_var, rsp_test_variance,
                              want.incident, rsp_incident,
                              want.invalid, rsp_variance_invalid);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_slot < NUM_SLOTS)
               operands[req_slot] = req_value;
            if (req_last)
               expected_verdicts.push_back(predict_incidence());
         end
      end
      n_pending = expected_verdicts.size();
   end

endmodule

// ===== bench/uncertain_point_line_incidence_tb.sv =====
// Testbench top for the point-line incidence block: clock, reset, operand and
// threshold stimulus, random stalls on the result side and the final verdict.
// Depends on upli_pkg, the block itself and upli_checker.
`timescale 1ns / 1ps

module uncertain_point_line_incidence_tb;
   import upli_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_PCT      = 31;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_ITEMS   = 280;
   localparam int NUM_PHASES    = 5;

   typedef enum int {
      STYLE_WIDE,
      STYLE_NARROW,
      STYLE_EXTREME,
      STYLE_CONDITIONED
   } value_style_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [SLOT_W-1:0]         req_slot    = '0;
   logic signed [VALUE_W-1:0] req_value   = '0;
   logic                      req_last    = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic signed [DIST_W-1:0]  rsp_alg_distance;
   logic signed [VAR_W-1:0]   rsp_alg_variance;
   logic signed [VAR_W-1:0]   rsp_test_variance;
   logic                      rsp_incident;
   logic                      rsp_variance_invalid;
   logic                      csr_wr_en   = 1'b0;
   logic [THR_W-1:0]          csr_wr_data = '0;

   int unsigned n_pending;
   int unsigned n_fail;
   int unsigned items_sent = 0;
   bit          calm       = 1'b0;
   bit          hold_go    = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   uncertain_point_line_incidence u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_slot             (req_slot),
      .req_value            (req_value),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_alg_distance     (rsp_alg_distance),
      .rsp_alg_variance     (rsp_alg_variance),
      .rsp_test_variance    (rsp_test_variance),
      .rsp_incident         (rsp_incident),
      .rsp_variance_invalid (rsp_variance_invalid),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   upli_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_slot             (req_slot),
      .req_value            (req_value),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_alg_distance     (rsp_alg_distance),
      .rsp_alg_variance     (rsp_alg_variance),
      .rsp_test_variance    (rsp_test_variance),
      .rsp_incident         (rsp_incident),
      .rsp_variance_invalid (rsp_variance_invalid),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .n_pending            (n_pending),
      .n_fail               (n_fail)
   );

   // Watchdog for a hung run.
   initial begin
      #(5_000_000);
      $display("tb: failure");
      $finish;
   end

   // Result side: random stalls, none while calm, and one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Offer one item after an optional random gap and wait until it is taken.
   task automatic send_item(input logic [SLOT_W-1:0] slot, input logic [VALUE_W-1:0] value,
                            input logic last);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_slot  <= slot;
      req_value <= value;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (slot < NUM_SLOTS || last)
         items_sent++;
   endtask

   // Drop valid and wait until every outstanding result is back and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (n_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] setting);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Element value for slot s; the conditioned style keeps covariances near diagonal.
   function automatic logic [VALUE_W-1:0] draw_value(input value_style_type style,
                                                     input int s);
      logic [VALUE_W-1:0] v;
      bit                 vec;
      bit                 diag;
      vec  = (s < SLOT_SX) || (s >= SLOT_L && s < SLOT_SL);
      diag = (s >= SLOT_SX && s < SLOT_L && (s - SLOT_SX) % 4 == 0) ||
             (s >= SLOT_SL && (s - SLOT_SL) % 4 == 0);
      case (style)
         STYLE_WIDE:    v = VALUE_W'($urandom());
         STYLE_NARROW:  v = VALUE_W'($urandom_range(0, 1023) - 512);
         STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       v = 16'h8000;
               1:       v = 16'h7FFF;
               2:       v = 16'h0000;
               3:       v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         default: begin
            if (vec)
               v = VALUE_W'($urandom_range(0, 2047) - 1024);
            else if (diag)
               v = VALUE_W'($urandom_range(1, 32767));
            else
               v = VALUE_W'($urandom_range(0, 64) - 32);
         end
      endcase
      return v;
   endfunction

   // A complete point and line, sometimes with the point on the line or at infinity,
   // sometimes in shuffled order, and now and then cut short without a last item.
   task automatic send_full_set();
      logic [VALUE_W-1:0] vals [NUM_SLOTS];
      int                 order [NUM_SLOTS];
      value_style_type    style;
      int                 a;
      int                 b;
      int                 j;
      int                 tmp;
      int                 stop;
      style = value_style_type'($urandom_range(0, 3));
      for (int i = 0; i < NUM_SLOTS; i++) begin
         vals[i]  = draw_value(style, i);
         order[i] = i;
      end
      if ($urandom_range(0, 9) < 4) begin
         // x = (a, b, w), l = (b, -a, 0) puts the point exactly on the line.
         a = $urandom_range(0, 2047) - 1024;
         b = $urandom_range(0, 2047) - 1024;
         vals[SLOT_X]     = VALUE_W'(a);
         vals[SLOT_X + 1] = VALUE_W'(b);
         vals[SLOT_L]     = VALUE_W'(b);
         vals[SLOT_L + 1] = VALUE_W'(-a);
         vals[SLOT_L + 2] = '0;
      end
      if ($urandom_range(0, 6) == 0)
         vals[SLOT_X + 2] = '0;
      if ($urandom_range(0, 1) == 1) begin
         for (int i = NUM_SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
      end
      stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NUM_SLOTS - 1) : NUM_SLOTS;
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(0, 29) == 0)
            send_item(SLOT_W'($urandom_range(NUM_SLOTS, 31)), VALUE_W'($urandom()), 1'b0);
         send_item(SLOT_W'(order[i]), vals[order[i]], i == NUM_SLOTS - 1);
      end
   endtask

   // A few element updates on top of the stored set, closed by a last item.
   task automatic send_update(input int n);
      value_style_type style;
      int              s;
      style = value_style_type'($urandom_range(0, 3));
      for (int k = 0; k < n; k++) begin
         s = $urandom_range(0, NUM_SLOTS - 1);
         send_item(SLOT_W'(s), draw_value(style, s), k == n - 1);
      end
   endtask

   task automatic run_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         send_full_set();
      else if (pick < 85)
         send_update($urandom_range(1, 4));
      else
         send_item(SLOT_W'($urandom_range(0, 31)), VALUE_W'($urandom()),
                   $urandom_range(0, 3) == 0);
   endtask

   // Main stimulus: reset, directed corner cases, then phases at several thresholds.
   initial begin
      logic [THR_W-1:0] setting;
      int unsigned      goal;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero vectors and extreme covariances: point at infinity, zero test variance.
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (s < SLOT_SX || (s >= SLOT_L && s < SLOT_SL))
            send_item(SLOT_W'(s), 16'h0000, 1'b0 );
         else
            send_item(SLOT_W'(s), (s % 2 == 1) ? 16'h8000 : 16'h7FFF, s == NUM_SLOTS - 1);
      end
      // Negative w with a negative line covariance gives a negative variance.
      send_item(SLOT_W'(SLOT_X + 2), 16'h8000, 1'b1);
      send_item(SLOT_W'(SLOT_L + 2), 16'h7FFF, 1'b1);
      // Out-of-range slots store nothing; with last set they still compute.
      send_item(5'd27, 16'h1234, 1'b0);
      send_item(5'd31, 16'h5A5A, 1'b1);
      // Positive variance, then a zero line so the point lies on it.
      send_item(SLOT_W'(SLOT_SL + 8), 16'h7FFF, 1'b1);
      send_item(SLOT_W'(SLOT_L + 2), 16'h0000, 1'b1);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         case (phase)
            0:       setting = '0;
            1:       setting = '1;
            3:       setting = THR_W'(1);
            default: setting = THR_W'($urandom());
         endcase
         write_threshold(setting);
         calm = (phase == 2);
         if (phase == 1) begin
            // Hold the result side off while last items keep coming.
            hold_go = 1'b1;
            repeat (12) send_update(1);
         end
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) run_sequence();
      end

      settle();
      if (n_fail == 0 && n_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== uncertain_point_line_incidence.f =====
+incdir+hdl
hdl/upli_pkg.sv
hdl/upli_ram.sv
hdl/upli_front.sv
hdl/upli_back.sv
hdl/uncertain_point_line_incidence.sv
hdl/upli_check.sv
bench/upli_checker.sv
bench/uncertain_point_line_incidence_tb.sv
